FILE: sv/rspat_pkg.sv
// Package for the range-sum tree: widths, reset values, request codes and
// the sequencer state type. No dependencies; used by range_sum_point_assign_tree.sv.
`default_nettype none

package rspat_pkg;

    // Default number of leaves in the tree.
    localparam int MAX_LEAVES_DEF = 1024;

    // Fixed field widths.
    localparam int VALUE_W = 64;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    // Reset value of the active leaf count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

    // Request codes carried in the input tuser.
    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_UP,
        S_QLO,
        S_QHI,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: sv/range_sum_point_assign_tree.sv
// Top level of the range-sum tree: sequencer, shared adder and node store.
// Depends on rspat_pkg and rspat_ram.
//
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid/s_axis_tready    func, position, value, range_first,
//                                                     range_last
// m_axis    out        m_axis_tvalid/m_axis_tready    range_sum
// cfg       in         cfg_we                         active_count
//
// Reset clears all 2*MAX_LEAVES nodes of the store, one node a cycle, with s_axis_tready low;
// configuration writes are taken meanwhile. An assign word passes through accept, a leaf
// write and one parent write per level; an assign beyond the active count is only accepted.
// A query word passes through accept, two steps per level, each at most one RAM read and
// one pass through the shared adder, a last bound check and emit; an empty range goes
// straight to emit, where it waits while the output register is full; no word enters then.
`default_nettype none

module range_sum_point_assign_tree #(
    parameter int MAX_LEAVES = rspat_pkg::MAX_LEAVES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input words.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: position[9:0], value[73:10], range_first[83:74],
    // range_last[93:84], zero fill[95:94].
    input  wire logic [95:0]                   s_axis_tdata,
    // Fields from bit 0: func[0].
    input  wire logic [0:0]                    s_axis_tuser,
    // Result words.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // Fields from bit 0: range_sum[63:0].
    output logic [rspat_pkg::VALUE_W-1:0]      m_axis_tdata,
    // Configuration.
    input  wire logic                          cfg_we,
    input  wire logic [rspat_pkg::COUNT_W-1:0] cfg_wdata
);

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int NW    = $clog2(DEPTH);
    localparam int HW    = NW + 1;
    localparam int CW    = (rspat_pkg::COUNT_W > NW) ? rspat_pkg::COUNT_W : NW;
    localparam int VW    = rspat_pkg::VALUE_W;
    localparam int PW    = rspat_pkg::POS_W;

    // Input field slices.
    logic          in_func;
    logic [PW-1:0] in_pos;
    logic [VW-1:0] in_value;
    logic [PW-1:0] in_first;
    logic [PW-1:0] in_last;

    assign in_func  = s_axis_tuser[0];
    assign in_pos   = s_axis_tdata[9:0];
    assign in_value = s_axis_tdata[73:10];
    assign in_first = s_axis_tdata[83:74];
    assign in_last  = s_axis_tdata[93:84];

    // Registers.
    rspat_pkg::state_t             state_reg, state_next;
    logic [rspat_pkg::COUNT_W-1:0] count_reg;
    logic [NW-1:0]                 clr_reg, clr_next;
    logic                          pend_reg, pend_next;
    logic                          out_valid_reg, out_valid_next;
    logic [VW-1:0]                 out_data_reg, out_data_next;
    logic [VW-1:0]                 sum_reg, sum_next;
    logic [NW-1:0]                 node_reg, node_next;
    logic [HW-1:0]                 lo_reg, lo_next;
    logic [HW-1:0]                 hi_reg, hi_next;

    // RAM port signals.
    logic          ram_we;
    logic [NW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic [NW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    // Shared adder: running sum plus the word read in the previous step.
    logic [VW-1:0] add_sum;

    assign add_sum = sum_reg + (pend_reg ? ram_rdata : '0);

    // Request decode: clip the count to the tree and the range to the count.
    logic [CW-1:0] eff_count;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] last_ext;
    logic [CW-1:0] last_clip;
    logic          assign_ok;
    logic          query_empty;
    logic [NW-1:0] leaf_node;
    logic [HW-1:0] lo_start;
    logic [HW-1:0] hi_start;

    always_comb
    begin
        cnt_ext     = CW'(count_reg);
        eff_count   = (cnt_ext > CW'(MAX_LEAVES)) ? CW'(MAX_LEAVES) : cnt_ext;
        last_ext    = CW'(in_last);
        last_clip   = (last_ext > eff_count - CW'(1)) ? eff_count - CW'(1) : last_ext;
        assign_ok   = CW'(in_pos) < eff_count;
        query_empty = (eff_count == '0) || (CW'(in_first) > last_clip);
        leaf_node   = NW'(CW'(in_pos) + CW'(MAX_LEAVES));
        lo_start    = HW'(in_first) + HW'(MAX_LEAVES);
        hi_start    = HW'(last_clip) + HW'(MAX_LEAVES) + HW'(1);
    end

    // Sequencer: next state, register updates and RAM control.
    logic [NW-1:0] parent;
    logic          out_free;

    assign parent   = node_reg >> 1;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        sum_next       = sum_reg;
        node_next      = node_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            rspat_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == NW'(DEPTH - 1))
                begin
                    state_next = rspat_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end

            rspat_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                pend_next     = 1'b0;
                if (s_axis_tvalid)
                begin
                    if (in_func == rspat_pkg::FUNC_QUERY)
                    begin
                        sum_next = '0;
                        lo_next  = lo_start;
                        hi_next  = hi_start;
                        state_next = query_empty ? rspat_pkg::S_EMIT : rspat_pkg::S_QLO;
                    end
                    else if (assign_ok)
                    begin
                        sum_next   = in_value;
                        node_next  = leaf_node;
                        state_next = rspat_pkg::S_LEAF;
                    end
                end
            end

            // Write the leaf and fetch its sibling.
            rspat_pkg::S_LEAF:
            begin
                ram_we     = 1'b1;
                ram_waddr  = node_reg;
                ram_wdata  = sum_reg;
                ram_raddr  = node_reg ^ NW'(1);
                pend_next  = 1'b1;
                state_next = rspat_pkg::S_UP;
            end

            // Write the parent sum and fetch the parent's sibling.
            rspat_pkg::S_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = add_sum;
                sum_next  = add_sum;
                node_next = parent;
                ram_raddr = parent ^ NW'(1);
                if (parent == NW'(1))
                begin
                    pend_next  = 1'b0;
                    state_next = rspat_pkg::S_IDLE;
                end
            end

            // Left bound step: stop when the bounds meet, else take an odd left node.
            rspat_pkg::S_QLO:
            begin
                sum_next  = add_sum;
                pend_next = 1'b0;
                if (lo_reg >= hi_reg)
                begin
                    state_next = rspat_pkg::S_EMIT;
                end
                else
                begin
                    if (lo_reg[0])
                    begin
                        ram_raddr = lo_reg[NW-1:0];
                        lo_next   = lo_reg + HW'(1);
                        pend_next = 1'b1;
                    end
                    state_next = rspat_pkg::S_QHI;
                end
            end

            // Right bound step: take an odd right node, then move both bounds up.
            rspat_pkg::S_QHI:
            begin
                sum_next  = add_sum;
                pend_next = 1'b0;
                if (hi_reg[0])
                begin
                    ram_raddr = NW'({hi_reg[HW-1:1], 1'b0});
                    pend_next = 1'b1;
                end
                lo_next    = lo_reg >> 1;
                hi_next    = hi_reg >> 1;
                state_next = rspat_pkg::S_QLO;
            end

            // Hand the sum to the output register once it is free.
            rspat_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_reg;
                    state_next     = rspat_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rspat_pkg::S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rspat_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= rspat_pkg::COUNT_RESET;
        end
        else
        begin
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        sum_reg      <= sum_next;
        node_reg     <= node_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Node store.
    rspat_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Queries only read the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rspat_pkg::S_QLO || state_reg == rspat_pkg::S_QHI) |-> !ram_we)
    else $error("store written during a query");

    // A result appears only out of the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == rspat_pkg::S_EMIT)
    else $error("result raised outside the emit step");

    // The upward walk never writes the unused node or the root's parent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rspat_pkg::S_UP) |-> node_reg > NW'(1))
    else $error("upward walk passed the root");

    // Query bounds stay inside the tree.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rspat_pkg::S_QLO || state_reg == rspat_pkg::S_QHI)
            |-> hi_reg <= HW'(DEPTH))
    else $error("query bound beyond the tree");

endmodule

`default_nettype wire

FILE: sv/rspat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rspat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
